[rtl/hht_pkg.sv]
// ----------------------------------------------------------------------------
// hht_pkg
// Shared types and character codes for the HTTP header tokenizer.
// ----------------------------------------------------------------------------
package hht_pkg;

  localparam int OFS_W  = 16;
  localparam int NTOK   = 3;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_COLON = 8'd58;

  typedef enum logic [2:0] {
    KIND_REQUEST    = 3'd0,
    KIND_HEADER     = 3'd1,
    KIND_DONE       = 3'd2,
    KIND_INCOMPLETE = 3'd3,
    KIND_OVERFLOW   = 3'd4
  } kind_t;

  // Results caused by one input word: an optional primary record and an
  // optional trailing incomplete record.
  typedef struct packed {
    logic                         prim_vld;
    kind_t                        kind;
    logic [NTOK-1:0][OFS_W-1:0]   starts;
    logic [NTOK-1:0][OFS_W-1:0]   stops;
    logic                         inc_vld;
    logic [OFS_W-1:0]             consumed;
  } group_t;

endpackage

[rtl/hht_parse.sv]
// ----------------------------------------------------------------------------
// hht_parse
// Tokenizer state and per-word classification of the request head.
// ----------------------------------------------------------------------------
module hht_parse import hht_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output group_t     grp
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                     req_r, req_nxt;
  logic [1:0]               td_r, td_nxt;
  logic                     inside_r, inside_nxt;
  logic [1:0]               lf_r, lf_nxt;
  logic [POSITION_BITS-1:0] parsed_r, parsed_nxt;
  logic                     fin_r, fin_nxt;
  logic [POSITION_BITS-1:0] starts_r [NTOK];
  logic [POSITION_BITS-1:0] starts_nxt [NTOK];
  logic [POSITION_BITS-1:0] stops_r [NTOK];
  logic [POSITION_BITS-1:0] stops_nxt [NTOK];

  logic       is_lf;
  logic       is_cr;
  logic       sep;
  logic [1:0] idx;
  logic [1:0] limit;
  logic [1:0] td_tmp;

  assign is_lf = (data_byte == CH_LF);
  assign is_cr = (data_byte == CH_CR);
  assign idx   = (td_r > 2'd2) ? 2'd2 : td_r;
  assign sep   = (data_byte == CH_SP) || (!req_r && (data_byte == CH_COLON));
  assign limit = req_r ? 2'd2 : 2'd1;

  always_comb begin
    pos_nxt    = pos_r;
    req_nxt    = req_r;
    td_nxt     = td_r;
    inside_nxt = inside_r;
    lf_nxt     = lf_r;
    parsed_nxt = parsed_r;
    fin_nxt    = fin_r;
    starts_nxt = starts_r;
    stops_nxt  = stops_r;
    td_tmp     = td_r;
    grp        = '0;
    grp.kind   = KIND_REQUEST;
    if (step) begin
      if (!fin_r) begin
        if (pos_r == POS_MAX) begin
          fin_nxt      = 1'b1;
          grp.prim_vld = 1'b1;
          grp.kind     = KIND_OVERFLOW;
        end else begin
          pos_nxt = pos_r + 1'b1;
          if (is_lf || is_cr) begin
            if (is_lf && (lf_r < 2'd2)) begin
              lf_nxt = lf_r + 2'd1;
            end
            if (lf_nxt >= 2'd2) begin
              fin_nxt      = 1'b1;
              grp.prim_vld = 1'b1;
              grp.kind     = KIND_DONE;
            end else begin
              if (inside_r) begin
                inside_nxt     = 1'b0;
                stops_nxt[idx] = pos_r;
                if (td_r < 2'd3) begin
                  td_tmp = td_r + 2'd1;
                end
              end
              td_nxt = td_tmp;
              if (td_tmp != 2'd0) begin
                if (req_r && (td_tmp == 2'd3)) begin
                  grp.prim_vld  = 1'b1;
                  grp.kind      = KIND_REQUEST;
                  grp.starts[0] = OFS_W'(starts_nxt[0]);
                  grp.stops[0]  = OFS_W'(stops_nxt[0]);
                  grp.starts[1] = OFS_W'(starts_nxt[1]);
                  grp.stops[1]  = OFS_W'(stops_nxt[1]);
                  grp.starts[2] = OFS_W'(starts_nxt[2]);
                  grp.stops[2]  = OFS_W'(stops_nxt[2]);
                  parsed_nxt    = stops_nxt[2] + 1'b1;
                end else if (!req_r && (td_tmp == 2'd2)) begin
                  grp.prim_vld  = 1'b1;
                  grp.kind      = KIND_HEADER;
                  grp.starts[0] = OFS_W'(starts_nxt[0]);
                  grp.stops[0]  = OFS_W'(stops_nxt[0]);
                  grp.starts[1] = OFS_W'(starts_nxt[1]);
                  grp.stops[1]  = OFS_W'(stops_nxt[1]);
                  parsed_nxt    = stops_nxt[1] + 1'b1;
                end
                td_nxt  = 2'd0;
                req_nxt = 1'b0;
              end
            end
          end else begin
            lf_nxt = 2'd0;
            if (sep) begin
              if (inside_r && (td_r < limit)) begin
                inside_nxt     = 1'b0;
                stops_nxt[idx] = pos_r;
                td_nxt         = td_r + 2'd1;
              end
            end else if (!inside_r) begin
              inside_nxt      = 1'b1;
              starts_nxt[idx] = pos_r;
            end
          end
        end
      end
      grp.consumed = OFS_W'(parsed_nxt);
      if (last_byte) begin
        grp.inc_vld = !fin_nxt;
        pos_nxt     = '0;
        req_nxt     = 1'b1;
        td_nxt      = 2'd0;
        inside_nxt  = 1'b0;
        lf_nxt      = 2'd0;
        parsed_nxt  = '0;
        fin_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      req_r    <= 1'b1;
      td_r     <= 2'd0;
      inside_r <= 1'b0;
      lf_r     <= 2'd0;
      parsed_r <= '0;
      fin_r    <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      req_r    <= req_nxt;
      td_r     <= td_nxt;
      inside_r <= inside_nxt;
      lf_r     <= lf_nxt;
      parsed_r <= parsed_nxt;
      fin_r    <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    starts_r <= starts_nxt;
    stops_r  <= stops_nxt;
  end

endmodule

[rtl/hht_outbuf.sv]
// ----------------------------------------------------------------------------
// hht_outbuf
// Result register that holds the records of one word and hands them out
// in order, one per accepted output word.
// ----------------------------------------------------------------------------
module hht_outbuf import hht_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  group_t           grp,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_record_kind,
  output logic [OFS_W-1:0] out_start_first,
  output logic [OFS_W-1:0] out_end_first,
  output logic [OFS_W-1:0] out_start_second,
  output logic [OFS_W-1:0] out_end_second,
  output logic [OFS_W-1:0] out_start_third,
  output logic [OFS_W-1:0] out_end_third,
  output logic [OFS_W-1:0] out_consumed,
  output logic             out_last_result
);

  group_t grp_r;
  logic   prim_r, prim_nxt;
  logic   inc_r, inc_nxt;
  logic   fire;

  assign out_valid       = prim_r || inc_r;
  assign out_last_result = prim_r ? !inc_r : 1'b1;
  assign fire            = out_valid && out_ready;
  assign free            = !out_valid || (fire && out_last_result);

  always_comb begin
    prim_nxt = prim_r;
    inc_nxt  = inc_r;
    if (load) begin
      prim_nxt = grp.prim_vld;
      inc_nxt  = grp.inc_vld;
    end else if (fire) begin
      if (prim_r) begin
        prim_nxt = 1'b0;
      end else begin
        inc_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prim_r <= 1'b0;
      inc_r  <= 1'b0;
    end else begin
      prim_r <= prim_nxt;
      inc_r  <= inc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp;
    end
  end

  always_comb begin
    out_consumed = grp_r.consumed;
    if (prim_r) begin
      out_record_kind  = grp_r.kind;
      out_start_first  = grp_r.starts[0];
      out_end_first    = grp_r.stops[0];
      out_start_second = grp_r.starts[1];
      out_end_second   = grp_r.stops[1];
      out_start_third  = grp_r.starts[2];
      out_end_third    = grp_r.stops[2];
    end else begin
      out_record_kind  = KIND_INCOMPLETE;
      out_start_first  = '0;
      out_end_first    = '0;
      out_start_second = '0;
      out_end_second   = '0;
      out_start_third  = '0;
      out_end_third    = '0;
    end
  end

endmodule

[rtl/http_header_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// http_header_tokenizer_core
// Finds token offsets in an HTTP request head, one byte per word.
//
//   Channel  Direction  Payload
//   in_      input      data_byte, last_byte
//   out_     output     record_kind, six token offsets, consumed, last_result
//
// A byte is registered, classified combinationally and its records are loaded
// into the result register, so one byte is taken every cycle while the result register is free.
// A byte that gives two records holds the result register until both are accepted.
// Reset is synchronous and active low and returns the parser to the start
// of a request line.
// Backpressure on out_ propagates combinationally to in_ready.
// ----------------------------------------------------------------------------
module http_header_tokenizer_core import hht_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_data_byte,
  input  logic             in_last_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_record_kind,
  output logic [OFS_W-1:0] out_start_first,
  output logic [OFS_W-1:0] out_end_first,
  output logic [OFS_W-1:0] out_start_second,
  output logic [OFS_W-1:0] out_end_second,
  output logic [OFS_W-1:0] out_start_third,
  output logic [OFS_W-1:0] out_end_third,
  output logic [OFS_W-1:0] out_consumed,
  output logic             out_last_result
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_data_r;
  logic       s1_last_r;
  logic       buf_free;
  logic       take;
  logic       in_fire;
  group_t     grp;

  assign take     = s1_valid_r && buf_free;
  assign in_ready = !s1_valid_r || buf_free;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  hht_parse #(
    .POSITION_BITS (POSITION_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (take),
    .data_byte (s1_data_r),
    .last_byte (s1_last_r),
    .grp       (grp)
  );

  hht_outbuf u_outbuf (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (take && (grp.prim_vld || grp.inc_vld)),
    .grp              (grp),
    .free             (buf_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_record_kind  (out_record_kind),
    .out_start_first  (out_start_first),
    .out_end_first    (out_end_first),
    .out_start_second (out_start_second),
    .out_end_second   (out_end_second),
    .out_start_third  (out_start_third),
    .out_end_third    (out_end_third),
    .out_consumed     (out_consumed),
    .out_last_result  (out_last_result)
  );

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// HTTP header tokenizer testbench
// Streams request heads into the tokenizer one byte per word and checks
// every record it returns against a cycle-free model of the parser. A short
// directed run covers the line, end and incomplete record kinds, malformed
// lines, CR handling, extra tokens and bytes after the end of the head.
// Random well-formed heads and noise follow.
// The sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import hht_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct {
    kind_t       kind;
    logic [15:0] start_first;
    logic [15:0] end_first;
    logic [15:0] start_second;
    logic [15:0] end_second;
    logic [15:0] start_third;
    logic [15:0] end_third;
    logic [15:0] consumed;
    logic        last;
  } record_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_data_byte = 8'd0;
  logic             in_last_byte = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [2:0]       out_record_kind;
  logic [OFS_W-1:0] out_start_first;
  logic [OFS_W-1:0] out_end_first;
  logic [OFS_W-1:0] out_start_second;
  logic [OFS_W-1:0] out_end_second;
  logic [OFS_W-1:0] out_start_third;
  logic [OFS_W-1:0] out_end_third;
  logic [OFS_W-1:0] out_consumed;
  logic             out_last_result;

  byte_item_t  bytes_to_send[$];
  logic [7:0]  frame[$];
  record_t     records_due[$];
  record_t     caused[$];
  int          mismatches = 0;
  int          items_queued = 0;

  // Parser state tracked alongside the block.
  logic [15:0] byte_offset;
  bit          on_request;
  logic [1:0]  tokens_closed;
  bit          in_token;
  logic [1:0]  lf_count;
  logic [15:0] tok_start[3];
  logic [15:0] tok_end[3];
  logic [15:0] parsed_end;
  bit          head_done;

  int          gap_left = 0;
  int          burst_left = 1;
  logic [15:0] stall_pattern = 16'hFFFF;
  logic [5:0]  stall_phase = 6'd0;

  http_header_tokenizer_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_record_kind  (out_record_kind),
    .out_start_first  (out_start_first),
    .out_end_first    (out_end_first),
    .out_start_second (out_start_second),
    .out_end_second   (out_end_second),
    .out_start_third  (out_start_third),
    .out_end_third    (out_end_third),
    .out_consumed     (out_consumed),
    .out_last_result  (out_last_result)
  );

  always #5 clk = ~clk;

  task automatic clear_parser();
    byte_offset = '0;
    on_request = 1'b1;
    tokens_closed = '0;
    in_token = 1'b0;
    lf_count = '0;
    foreach (tok_start[i]) begin
      tok_start[i] = '0;
      tok_end[i] = '0;
    end
    parsed_end = '0;
    head_done = 1'b0;
  endtask

  function automatic record_t make_record(kind_t kind, int ntok);
    record_t r;
    r.kind = kind;
    r.start_first = (ntok > 0) ? tok_start[0] : '0;
    r.end_first = (ntok > 0) ? tok_end[0] : '0;
    r.start_second = (ntok > 1) ? tok_start[1] : '0;
    r.end_second = (ntok > 1) ? tok_end[1] : '0;
    r.start_third = (ntok > 2) ? tok_start[2] : '0;
    r.end_third = (ntok > 2) ? tok_end[2] : '0;
    r.consumed = parsed_end;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic tokenize_byte(input logic [7:0] c, input logic last);
    logic [15:0] pos;
    bit          is_sep;
    int          idx;
    caused.delete();
    if (!head_done) begin
      if (byte_offset == 16'hFFFF) begin
        head_done = 1'b1;
        caused.push_back(make_record(KIND_OVERFLOW, 0));
      end else begin
        pos = byte_offset;
        byte_offset = byte_offset + 16'd1;
        idx = (tokens_closed > 2) ? 2 : tokens_closed;
        if (c == CH_LF || c == CH_CR) begin
          if (c == CH_LF && lf_count < 2) lf_count = lf_count + 2'd1;
          if (lf_count >= 2) begin
            head_done = 1'b1;
            caused.push_back(make_record(KIND_DONE, 0));
          end else begin
            if (in_token) begin
              in_token = 1'b0;
              tok_end[idx] = pos;
              if (tokens_closed < 3) tokens_closed = tokens_closed + 2'd1;
            end
            if (tokens_closed != 0) begin
              if (on_request && tokens_closed == 3) begin
                parsed_end = tok_end[2] + 16'd1;
                caused.push_back(make_record(KIND_REQUEST, 3));
              end else if (!on_request && tokens_closed == 2) begin
                parsed_end = tok_end[1] + 16'd1;
                caused.push_back(make_record(KIND_HEADER, 2));
              end
              tokens_closed = '0;
              on_request = 1'b0;
            end
          end
        end else begin
          lf_count = '0;
          is_sep = on_request ? (c == CH_SP) : (c == CH_SP || c == CH_COLON);
          if (is_sep) begin
            if (in_token && tokens_closed < (on_request ? 2 : 1)) begin
              in_token = 1'b0;
              tok_end[idx] = pos;
              tokens_closed = tokens_closed + 2'd1;
            end
          end else if (!in_token) begin
            in_token = 1'b1;
            tok_start[idx] = pos;
          end
        end
      end
    end
    if (last) begin
      if (!head_done) caused.push_back(make_record(KIND_INCOMPLETE, 0));
      clear_parser();
    end
    if (caused.size() > 0) caused[caused.size() - 1].last = 1'b1;
    foreach (caused[i]) records_due.push_back(caused[i]);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  function automatic logic [7:0] token_char(bit colon_ok);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CH_LF || c == CH_CR || c == CH_SP || (!colon_ok && c == CH_COLON));
    return c;
  endfunction

  task automatic push_token(int n, bit colon_ok);
    repeat (n) frame.push_back(token_char(colon_ok));
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) frame.push_back(s[i]);
  endtask

  task automatic push_line_end();
    if ($urandom_range(0, 1)) frame.push_back(CH_CR);
    frame.push_back(CH_LF);
  endtask

  task automatic send_frame();
    byte_item_t item;
    foreach (frame[i]) begin
      item.data = frame[i];
      item.last = (i == frame.size() - 1);
      bytes_to_send.push_back(item);
    end
    items_queued += frame.size();
    frame.delete();
  endtask

  task automatic build_random_head();
    int nhdr;
    int cut;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 20)) begin
        case ($urandom_range(0, 5))
          0: frame.push_back(CH_LF);
          1: frame.push_back(CH_CR);
          2: frame.push_back(CH_SP);
          3: frame.push_back(CH_COLON);
          default: frame.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      return;
    end
    push_token($urandom_range(1, 4), 1'b1);
    repeat ($urandom_range(1, 2)) frame.push_back(CH_SP);
    push_token($urandom_range(1, 5), 1'b1);
    if ($urandom_range(0, 7) != 0) begin
      frame.push_back(CH_SP);
      push_token($urandom_range(1, 4), 1'b1);
      if ($urandom_range(0, 3) == 0) begin
        frame.push_back(CH_SP);
        push_token($urandom_range(1, 3), 1'b1);
      end
    end
    push_line_end();
    nhdr = $urandom_range(0, 3);
    repeat (nhdr) begin
      push_token($urandom_range(1, 4), 1'b0);
      if ($urandom_range(0, 7) != 0) begin
        case ($urandom_range(0, 3))
          0: frame.push_back(CH_COLON);
          1: frame.push_back(CH_SP);
          2: push_text(": ");
          default: push_text(":  ");
        endcase
        push_token($urandom_range(1, 5), 1'b1);
        if ($urandom_range(0, 2) == 0) begin
          frame.push_back($urandom_range(0, 1) ? CH_SP : CH_COLON);
          push_token($urandom_range(1, 3), 1'b1);
        end
      end
      push_line_end();
    end
    push_line_end();
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, frame.size());
      while (frame.size() > cut) void'(frame.pop_back());
    end
  endtask

  // Sender: bursts of words separated by random gaps.
  always @(posedge clk) begin
    byte_item_t cur;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0 || bytes_to_send.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left = gap_left - 1;
      end else begin
        cur = bytes_to_send.pop_front();
        in_valid <= 1'b1;
        in_data_byte <= cur.data;
        in_last_byte <= cur.last;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left = burst_left - 1;
        end
      end
    end
  end

  // Receiver: a 16-bit ready pattern, played in turn and redrawn each time the 6-bit phase wraps.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_phase == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pattern = 16'hFFFF;
          1: stall_pattern = 16'($urandom) | 16'h8888;
          2: stall_pattern = (16'($urandom) & 16'($urandom)) | 16'h8888;
          default: stall_pattern = 16'($urandom) | 16'($urandom);
        endcase
      end
      out_ready <= stall_pattern[stall_phase[3:0]];
      stall_phase <= stall_phase + 6'd1;
    end
  end

  always @(posedge clk) begin
    record_t want;
    if (rst_n) begin
      if (in_valid && in_ready) tokenize_byte(in_data_byte, in_last_byte);
      if (out_valid && out_ready) begin
        if (records_due.size() == 0) begin
          $display("%0t: record expected none actual kind %0d", $time, out_record_kind);
          mismatches++;
        end else begin
          want = records_due.pop_front();
          check_field("record_kind", 16'(want.kind), 16'(out_record_kind));
          check_field("start_first", want.start_first, out_start_first);
          check_field("end_first", want.end_first, out_end_first);
          check_field("start_second", want.start_second, out_start_second);
          check_field("end_second", want.end_second, out_end_second);
          check_field("start_third", want.start_third, out_start_third);
          check_field("end_third", want.end_third, out_end_third);
          check_field("consumed", want.consumed, out_consumed);
          check_field("last_result", 16'(want.last), 16'(out_last_result));
        end
      end
    end
  end

  initial begin
    clear_parser();

    // Request line with a spaced version, one header, blank line, then
    // bytes after the end with the last one marked.
    push_text("A B C D");
    frame.push_back(CH_LF);
    push_text("N:V");
    frame.push_back(CH_LF);
    frame.push_back(CH_LF);
    frame.push_back(8'hFF);
    frame.push_back(8'h00);
    send_frame();

    // One-token request line ended by CR, then a header whose value holds
    // a space and a colon, cut off by the last byte.
    push_text("X");
    frame.push_back(CH_CR);
    push_text("K: v :w");
    frame.push_back(CH_LF);
    send_frame();

    while (items_queued < 800) begin
      build_random_head();
      send_frame();
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_to_send.size() != 0 || in_valid || records_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[files.f]
rtl/hht_pkg.sv
rtl/hht_parse.sv
rtl/hht_outbuf.sv
rtl/http_header_tokenizer_core.sv
verif/testbench.sv
